FILE: sv/bilinear_table_lookup_macros.svh
// Assertion macros for the bilinear table lookup
`ifndef BILINEAR_TABLE_LOOKUP_MACROS_SVH
`define BILINEAR_TABLE_LOOKUP_MACROS_SVH

// check a property outside reset
`define BLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check a property at every edge, reset included
`define BLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: sv/blt_pkg.sv
// Shared constants and types of the bilinear table lookup
`timescale 1ns / 1ps
package blt_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int MAP_DEPTH   = MAX_ROWS * MAX_COLUMNS;

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLUMNS);
    localparam int MAP_AW = $clog2(MAP_DEPTH);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLUMNS + 1);

    localparam int PTS_W  = 5;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 16;
    localparam int NUM_W  = 2 * VAL_W + 1;
    localparam int ADDR_W = 3;
    localparam int REG_IW = ADDR_W - 2;
    localparam int DATA_W = 32;

    localparam logic [REG_IW-1:0] REG_ROW_POINTS    = REG_IW'(0);
    localparam logic [REG_IW-1:0] REG_COLUMN_POINTS = REG_IW'(1);

    typedef enum logic [1:0] {
        ACT_LOAD_ROW    = 2'd0,
        ACT_LOAD_COLUMN = 2'd1,
        ACT_LOAD_CELL   = 2'd2,
        ACT_LOOKUP      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_TOP    = 2'd0,
        OP_BOTTOM = 2'd1,
        OP_FINAL  = 2'd2
    } op_t;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_RLO   = 15'b000000000000010,
        ST_RHI   = 15'b000000000000100,
        ST_RSCAN = 15'b000000000001000,
        ST_CLO   = 15'b000000000010000,
        ST_CHI   = 15'b000000000100000,
        ST_CSCAN = 15'b000000001000000,
        ST_M0    = 15'b000000010000000,
        ST_M1    = 15'b000000100000000,
        ST_M2    = 15'b000001000000000,
        ST_M3    = 15'b000010000000000,
        ST_MUL   = 15'b000100000000000,
        ST_DIVS  = 15'b001000000000000,
        ST_DIVW  = 15'b010000000000000,
        ST_FIN   = 15'b100000000000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: sv/blt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module blt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/blt_div.sv
// Bit-serial signed divider, truncating toward zero, 16-bit wrapped quotient
`timescale 1ns / 1ps
module blt_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [blt_pkg::NUM_W-1:0]  num,
    input  logic signed [blt_pkg::VAL_W-1:0]  den,
    output blt_pkg::div_status_t              status,
    output logic signed [blt_pkg::VAL_W-1:0]  quo
);

    localparam int NW = blt_pkg::NUM_W;
    localparam int DW = blt_pkg::VAL_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] dmag_reg, dmag_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   shifted;
    logic          fits;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dmag_next = dmag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        shifted   = {rem_reg, q_reg[NW-1]};
        fits      = shifted >= {1'b0, dmag_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            neg_next  = num[NW-1] ^ den[DW-1];
            dmag_next = den[DW-1] ? DW'(-den) : DW'(den);
            rem_next  = '0;
            q_next    = num[NW-1] ? NW'(-num) : NW'(num);
        end else if (busy_reg) begin
            rem_next = fits ? DW'(shifted - {1'b0, dmag_reg}) : DW'(shifted);
            q_next   = {q_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo = neg_reg ? DW'(-q_reg[DW-1:0]) : q_reg[DW-1:0];

endmodule

FILE: sv/bilinear_table_lookup.sv
// Top level of the bilinear table lookup: sequencer, stores and config port
//
//  channel | direction | handshake            | word
//  s_      | in        | s_valid / s_ready    | action, entry_index, entry_value, query
//  m_      | out       | m_valid / m_ready    | interpolated
//  apb     | in        | psel, penable, pready| row_points, column_points
//
// A load does not leave idle. A lookup holds s_ready low from its accept until it is back in
// idle, through R row and C column scan steps (at most points-2 each) and B 33-bit divisions
// (0 to 3), which all run on the one bit-serial divider.
// The stores have no reset; aresetn clears the sequencer and sets the point counts to 2.
// A waiting result sits in the output register; loads are still taken then.
`timescale 1ns / 1ps
`include "bilinear_table_lookup_macros.svh"
module bilinear_table_lookup (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blt_pkg::ADDR_W-1:0]         paddr,
    input  logic [blt_pkg::DATA_W-1:0]         pwdata,
    output logic [blt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [blt_pkg::IDX_W-1:0]          s_entry_index,
    input  logic signed [16:0]                 s_entry_value,
    input  logic signed [blt_pkg::VAL_W-1:0]   s_query_row,
    input  logic [blt_pkg::VAL_W-1:0]          s_query_column,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [blt_pkg::VAL_W-1:0]   m_interpolated
);

    localparam int VW = blt_pkg::VAL_W;
    localparam int RA = blt_pkg::ROW_AW;
    localparam int CA = blt_pkg::COL_AW;
    localparam int MA = blt_pkg::MAP_AW;
    localparam int RC = blt_pkg::ROW_CW;
    localparam int CC = blt_pkg::COL_CW;
    localparam int NW = blt_pkg::NUM_W;

    blt_pkg::state_t state_reg, state_next;
    blt_pkg::op_t    op_reg, op_next;

    logic [blt_pkg::PTS_W-1:0] row_points_reg, column_points_reg;
    logic [RC-1:0] nr_reg, nr_next;
    logic [CC-1:0] nc_reg, nc_next;
    logic [RA-1:0] r_reg, r_next;
    logic [CA-1:0] c_reg, c_next;
    logic [MA-1:0] base_reg, base_next, base_calc;
    logic [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic [VW-1:0] rlo_reg, rlo_next, rhi_reg, rhi_next;
    logic [VW-1:0] clo_reg, clo_next, chi_reg, chi_next;
    logic [VW-1:0] c00_reg, c00_next, c01_reg, c01_next;
    logic [VW-1:0] c10_reg, c10_next, c11_reg, c11_next;
    logic [VW-1:0] d0c_reg, d0c_next, d1c_reg, d1c_next, denc_reg, denc_next;
    logic [VW-1:0] d0r_reg, d0r_next, d1r_reg, d1r_next, denr_reg, denr_next;
    logic [VW-1:0] za_reg, za_next, zb_reg, zb_next, res_reg, res_next;
    logic signed [2*VW-1:0] p0_reg, p0_next, p1_reg, p1_next;
    logic [VW-1:0] mul_a, mul_b, mul_wa, mul_wb;
    logic [VW-1:0] denc_calc, denr_calc;
    logic          m_valid_reg, m_valid_next;
    logic [VW-1:0] m_data_reg, m_data_next;

    logic          accept;
    logic          row_we, col_we, map_we;
    logic [RA-1:0] row_raddr;
    logic [CA-1:0] col_raddr;
    logic [MA-1:0] map_raddr;
    logic [VW-1:0] row_rdata, col_rdata, map_rdata;

    logic                  div_start;
    logic signed [NW-1:0]  div_num;
    logic signed [VW-1:0]  div_den;
    blt_pkg::div_status_t  div_status;
    logic signed [VW-1:0]  div_quo;

    logic                  cfg_write;
    logic [blt_pkg::REG_IW-1:0] cfg_index;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[blt_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_points_reg    <= blt_pkg::PTS_W'(2);
            column_points_reg <= blt_pkg::PTS_W'(2);
        end else if (cfg_write) begin
            if (cfg_index == blt_pkg::REG_ROW_POINTS) begin
                row_points_reg <= pwdata[blt_pkg::PTS_W-1:0];
            end
            if (cfg_index == blt_pkg::REG_COLUMN_POINTS) begin
                column_points_reg <= pwdata[blt_pkg::PTS_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_index == blt_pkg::REG_COLUMN_POINTS) begin
            prdata[blt_pkg::PTS_W-1:0] = column_points_reg;
        end else begin
            prdata[blt_pkg::PTS_W-1:0] = row_points_reg;
        end
    end

    // stores
    assign s_ready = (state_reg == blt_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign row_we  = accept && (s_action == blt_pkg::ACT_LOAD_ROW)
                     && (int'(s_entry_index) < blt_pkg::MAX_ROWS);
    assign col_we  = accept && (s_action == blt_pkg::ACT_LOAD_COLUMN)
                     && (int'(s_entry_index) < blt_pkg::MAX_COLUMNS);
    assign map_we  = accept && (s_action == blt_pkg::ACT_LOAD_CELL)
                     && (int'(s_entry_index) < blt_pkg::MAP_DEPTH);

    blt_ram #(.WIDTH(VW), .DEPTH(blt_pkg::MAX_ROWS)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (RA'(s_entry_index)),
        .wdata (s_entry_value[VW-1:0]),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    blt_ram #(.WIDTH(VW), .DEPTH(blt_pkg::MAX_COLUMNS)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (CA'(s_entry_index)),
        .wdata (s_entry_value[VW-1:0]),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    blt_ram #(.WIDTH(VW), .DEPTH(blt_pkg::MAP_DEPTH)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (MA'(s_entry_index)),
        .wdata (s_entry_value[VW-1:0]),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    blt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .status  (div_status),
        .quo     (div_quo)
    );

    assign base_calc = MA'(MA'(r_reg) * MA'(nc_reg) + MA'(c_reg));
    assign denc_calc = chi_reg - clo_reg;
    assign denr_calc = rhi_reg - rlo_reg;
    assign div_num   = NW'(p0_reg) + NW'(p1_reg);
    assign div_den   = (op_reg == blt_pkg::OP_FINAL) ? denr_reg : denc_reg;
    assign div_start = (state_reg == blt_pkg::ST_DIVS);

    // read addresses
    always_comb begin
        row_raddr = '0;
        col_raddr = '0;
        map_raddr = base_calc;
        unique case (state_reg)
            blt_pkg::ST_RLO:   row_raddr = RA'(nr_reg - RC'(1));
            blt_pkg::ST_RHI:   row_raddr = RA'(1);
            blt_pkg::ST_RSCAN: row_raddr = RA'(r_reg + RA'(2));
            blt_pkg::ST_CLO:   col_raddr = CA'(nc_reg - CC'(1));
            blt_pkg::ST_CHI:   col_raddr = CA'(1);
            blt_pkg::ST_CSCAN: col_raddr = CA'(c_reg + CA'(2));
            blt_pkg::ST_M0:    map_raddr = base_reg + MA'(1);
            blt_pkg::ST_M1:    map_raddr = base_reg + MA'(nc_reg);
            blt_pkg::ST_M2:    map_raddr = base_reg + MA'(nc_reg) + MA'(1);
            default: begin
                row_raddr = '0;
            end
        endcase
    end

    // multiplier operands
    always_comb begin
        unique case (op_reg)
            blt_pkg::OP_TOP: begin
                mul_a = c00_reg; mul_b = c01_reg; mul_wa = d1c_reg; mul_wb = d0c_reg;
            end
            blt_pkg::OP_BOTTOM: begin
                mul_a = c10_reg; mul_b = c11_reg; mul_wa = d1c_reg; mul_wb = d0c_reg;
            end
            default: begin
                mul_a = za_reg; mul_b = zb_reg; mul_wa = d1r_reg; mul_wb = d0r_reg;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        nr_next      = nr_reg;
        nc_next      = nc_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        base_next    = base_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        clo_next     = clo_reg;
        chi_next     = chi_reg;
        c00_next     = c00_reg;
        c01_next     = c01_reg;
        c10_next     = c10_reg;
        c11_next     = c11_reg;
        d0c_next     = d0c_reg;
        d1c_next     = d1c_reg;
        denc_next    = denc_reg;
        d0r_next     = d0r_reg;
        d1r_next     = d1r_reg;
        denr_next    = denr_reg;
        za_next      = za_reg;
        zb_next      = zb_reg;
        res_next     = res_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            blt_pkg::ST_IDLE: begin
                if (accept && (s_action == blt_pkg::ACT_LOOKUP)) begin
                    x_next = s_query_row;
                    y_next = s_query_column;
                    if (row_points_reg < blt_pkg::PTS_W'(2)) begin
                        nr_next = RC'(2);
                    end else if (int'(row_points_reg) > blt_pkg::MAX_ROWS) begin
                        nr_next = RC'(blt_pkg::MAX_ROWS);
                    end else begin
                        nr_next = RC'(row_points_reg);
                    end
                    if (column_points_reg < blt_pkg::PTS_W'(2)) begin
                        nc_next = CC'(2);
                    end else if (int'(column_points_reg) > blt_pkg::MAX_COLUMNS) begin
                        nc_next = CC'(blt_pkg::MAX_COLUMNS);
                    end else begin
                        nc_next = CC'(column_points_reg);
                    end
                    state_next = blt_pkg::ST_RLO;
                end
            end
            blt_pkg::ST_RLO: begin
                rlo_next = row_rdata;
                if ($signed(x_reg) < $signed(row_rdata)) begin
                    x_next = row_rdata;
                end
                state_next = blt_pkg::ST_RHI;
            end
            blt_pkg::ST_RHI: begin
                if ($signed(x_reg) > $signed(row_rdata)) begin
                    x_next = row_rdata;
                end
                r_next     = '0;
                state_next = blt_pkg::ST_RSCAN;
            end
            blt_pkg::ST_RSCAN: begin
                if ((RC'(r_reg) < nr_reg - RC'(2)) && ($signed(x_reg) > $signed(row_rdata))) begin
                    r_next   = r_reg + RA'(1);
                    rlo_next = row_rdata;
                end else begin
                    rhi_next   = row_rdata;
                    state_next = blt_pkg::ST_CLO;
                end
            end
            blt_pkg::ST_CLO: begin
                clo_next = col_rdata;
                if (y_reg < col_rdata) begin
                    y_next = col_rdata;
                end
                state_next = blt_pkg::ST_CHI;
            end
            blt_pkg::ST_CHI: begin
                if (y_reg > col_rdata) begin
                    y_next = col_rdata;
                end
                c_next     = '0;
                state_next = blt_pkg::ST_CSCAN;
            end
            blt_pkg::ST_CSCAN: begin
                if ((CC'(c_reg) < nc_reg - CC'(2)) && (y_reg > col_rdata)) begin
                    c_next   = c_reg + CA'(1);
                    clo_next = col_rdata;
                end else begin
                    chi_next   = col_rdata;
                    base_next  = base_calc;
                    state_next = blt_pkg::ST_M0;
                end
            end
            blt_pkg::ST_M0: begin
                c00_next   = map_rdata;
                state_next = blt_pkg::ST_M1;
            end
            blt_pkg::ST_M1: begin
                c01_next   = map_rdata;
                state_next = blt_pkg::ST_M2;
            end
            blt_pkg::ST_M2: begin
                c10_next   = map_rdata;
                state_next = blt_pkg::ST_M3;
            end
            blt_pkg::ST_M3: begin
                c11_next  = map_rdata;
                d0c_next  = y_reg - clo_reg;
                d1c_next  = chi_reg - y_reg;
                denc_next = denc_calc;
                d0r_next  = x_reg - rlo_reg;
                d1r_next  = rhi_reg - x_reg;
                denr_next = denr_calc;
                if (denc_calc != '0) begin
                    op_next    = blt_pkg::OP_TOP;
                    state_next = blt_pkg::ST_MUL;
                end else begin
                    za_next = c00_reg;
                    zb_next = c10_reg;
                    if (denr_calc != '0) begin
                        op_next    = blt_pkg::OP_FINAL;
                        state_next = blt_pkg::ST_MUL;
                    end else begin
                        res_next   = c00_reg;
                        state_next = blt_pkg::ST_FIN;
                    end
                end
            end
            blt_pkg::ST_MUL: begin
                p0_next    = $signed(mul_wa) * $signed(mul_a);
                p1_next    = $signed(mul_wb) * $signed(mul_b);
                state_next = blt_pkg::ST_DIVS;
            end
            blt_pkg::ST_DIVS: begin
                state_next = blt_pkg::ST_DIVW;
            end
            blt_pkg::ST_DIVW: begin
                if (div_status.done) begin
                    unique case (op_reg)
                        blt_pkg::OP_TOP: begin
                            za_next    = div_quo;
                            op_next    = blt_pkg::OP_BOTTOM;
                            state_next = blt_pkg::ST_MUL;
                        end
                        blt_pkg::OP_BOTTOM: begin
                            zb_next = div_quo;
                            if (denr_reg != '0) begin
                                op_next    = blt_pkg::OP_FINAL;
                                state_next = blt_pkg::ST_MUL;
                            end else begin
                                res_next   = za_reg;
                                state_next = blt_pkg::ST_FIN;
                            end
                        end
                        default: begin
                            res_next   = div_quo;
                            state_next = blt_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            blt_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = blt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= blt_pkg::ST_IDLE;
            op_reg      <= blt_pkg::OP_TOP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
        nr_reg     <= nr_next;
        nc_reg     <= nc_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        base_reg   <= base_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        clo_reg    <= clo_next;
        chi_reg    <= chi_next;
        c00_reg    <= c00_next;
        c01_reg    <= c01_next;
        c10_reg    <= c10_next;
        c11_reg    <= c11_next;
        d0c_reg    <= d0c_next;
        d1c_reg    <= d1c_next;
        denc_reg   <= denc_next;
        d0r_reg    <= d0r_next;
        d1r_reg    <= d1r_next;
        denr_reg   <= denr_next;
        za_reg     <= za_next;
        zb_reg     <= zb_next;
        res_reg    <= res_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_interpolated = m_data_reg;

    `BLT_ASSERT(a_row_scan_bound, (state_reg == blt_pkg::ST_RSCAN) |-> (RC'(r_reg) <= nr_reg - RC'(2)), "row scan past last interval")
    `BLT_ASSERT(a_col_scan_bound, (state_reg == blt_pkg::ST_CSCAN) |-> (CC'(c_reg) <= nc_reg - CC'(2)), "column scan past last interval")
    `BLT_ASSERT(a_result_from_fin, $rose(m_valid_reg) |-> $past(state_reg == blt_pkg::ST_FIN), "result word loaded outside finish")
    `BLT_ASSERT_ALWAYS(a_idle_div_quiet, (aresetn && state_reg == blt_pkg::ST_IDLE) |-> !div_status.busy, "divider busy while idle")

endmodule

FILE: tb/tb_bilinear_table_lookup.sv
// Self-checking testbench of the bilinear table lookup: directed table, random loads and lookups
`timescale 1ns / 1ps
module tb_bilinear_table_lookup;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [blt_pkg::ADDR_W-1:0] paddr = '0;
    logic [blt_pkg::DATA_W-1:0] pwdata = '0;
    logic [blt_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_action = blt_pkg::ACT_LOAD_ROW;
    logic [blt_pkg::IDX_W-1:0] s_entry_index = '0;
    logic signed [16:0] s_entry_value = '0;
    logic signed [15:0] s_query_row = '0;
    logic [15:0] s_query_column = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_interpolated;

    bilinear_table_lookup uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    logic signed [15:0] row_bp [blt_pkg::MAX_ROWS];
    logic [15:0] col_bp [blt_pkg::MAX_COLUMNS];
    logic signed [15:0] cells [blt_pkg::MAP_DEPTH];
    logic [4:0] rows_cfg, cols_cfg;
    logic signed [15:0] pending_values [$];
    int mismatches = 0;
    int cycles = 0;
    int out_wait = 0;
    int out_draw;
    int cfg_r [8] = '{2, 16, 0, 31, 3, 9, 1, 17};
    int cfg_c [8] = '{16, 2, 31, 0, 5, 1, 12, 17};
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        blt_pkg::action_t act;
        int idx;
        int val;
        int qr;
        int qc;
        bit known;
        int want;
    } row_t;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic signed [15:0] blend_div(input logic signed [15:0] d0,
            input logic signed [15:0] d1, input logic signed [15:0] den,
            input logic signed [15:0] za, input logic signed [15:0] zb);
        longint num;
        num = longint'(d1) * za + longint'(d0) * zb;
        return 16'(num / longint'(den));
    endfunction

    function automatic int npts(input logic [4:0] n, input int maxn);
        if (n < 2) return 2;
        if (n > maxn) return maxn;
        return n;
    endfunction

    function automatic logic signed [15:0] interpolate(input logic signed [15:0] qr,
            input logic [15:0] qc);
        int nr, nc, r, c, base;
        logic signed [15:0] x, d0, d1, den, za, zb;
        logic [15:0] y;
        nr = npts(rows_cfg, blt_pkg::MAX_ROWS);
        nc = npts(cols_cfg, blt_pkg::MAX_COLUMNS);
        x = qr;
        y = qc;
        if (x < row_bp[0]) x = row_bp[0];
        if (x > row_bp[nr-1]) x = row_bp[nr-1];
        r = 0;
        while (r < nr - 2 && x > row_bp[r+1]) r++;
        if (y < col_bp[0]) y = col_bp[0];
        if (y > col_bp[nc-1]) y = col_bp[nc-1];
        c = 0;
        while (c < nc - 2 && y > col_bp[c+1]) c++;
        base = r * nc + c;
        d0 = 16'(int'(y) - int'(col_bp[c]));
        d1 = 16'(int'(col_bp[c+1]) - int'(y));
        den = d0 + d1;
        if (den == 0) begin
            za = cells[base];
            zb = cells[base+nc];
        end else begin
            za = blend_div(d0, d1, den, cells[base], cells[base+1]);
            zb = blend_div(d0, d1, den, cells[base+nc], cells[base+nc+1]);
        end
        d0 = 16'(int'(x) - int'(row_bp[r]));
        d1 = 16'(int'(row_bp[r+1]) - int'(x));
        den = d0 + d1;
        if (den == 0) return za;
        return blend_div(d0, d1, den, za, zb);
    endfunction

    task automatic apply_word(input blt_pkg::action_t act, input int idx, input int val,
            input int qr, input int qc);
        logic [15:0] v;
        v = 16'(val);
        case (act)
            blt_pkg::ACT_LOAD_ROW: if (idx < blt_pkg::MAX_ROWS) row_bp[idx] = v;
            blt_pkg::ACT_LOAD_COLUMN: if (idx < blt_pkg::MAX_COLUMNS) col_bp[idx] = v;
            blt_pkg::ACT_LOAD_CELL: if (idx < blt_pkg::MAP_DEPTH) cells[idx] = v;
            default: pending_values.push_back(interpolate(16'(qr), 16'(qc)));
        endcase
    endtask

    task automatic send_word(input blt_pkg::action_t act, input int idx, input int val,
            input int qr, input int qc);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_entry_index <= 8'(idx);
        s_entry_value <= 17'(val);
        s_query_row <= 16'(qr);
        s_query_column <= 16'(qc);
        apply_word(act, idx, val, qr, qc);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [blt_pkg::ADDR_W-1:0] reg_idx, input int value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= blt_pkg::ADDR_W'(reg_idx * 4);
        pwdata <= blt_pkg::DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == blt_pkg::ADDR_W'(blt_pkg::REG_ROW_POINTS)) rows_cfg = 5'(value);
        else if (reg_idx == blt_pkg::ADDR_W'(blt_pkg::REG_COLUMN_POINTS)) cols_cfg = 5'(value);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // non-decreasing breakpoints and a full map for the current point counts
    task automatic fill_table(input bit narrow);
        int nr, nc, v, step;
        nr = npts(rows_cfg, blt_pkg::MAX_ROWS);
        nc = npts(cols_cfg, blt_pkg::MAX_COLUMNS);
        v = narrow ? $urandom_range(0, 20) - 10 : $urandom_range(0, 4000) - 32768;
        for (int i = 0; i < nr; i++) begin
            send_word(blt_pkg::ACT_LOAD_ROW, i, v, 0, 0);
            step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, narrow ? 3 : 4000);
            v += step;
        end
        v = narrow ? $urandom_range(0, 10) : $urandom_range(0, 3000);
        for (int i = 0; i < nc; i++) begin
            send_word(blt_pkg::ACT_LOAD_COLUMN, i, v, 0, 0);
            step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, narrow ? 3 : 4000);
            v += step;
        end
        for (int i = 0; i < nr * nc; i++)
            send_word(blt_pkg::ACT_LOAD_CELL, i, $urandom_range(0, 65535) - 32768, 0, 0);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
            out_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) report("unexpected word", m_interpolated, 0);
                else begin
                    if (m_interpolated !== pending_values[0])
                        report("interpolated", m_interpolated, pending_values[0]);
                    void'(pending_values.pop_front());
                end
                out_draw = $urandom_range(0, 7);
                m_ready <= (out_draw == 0);
                out_wait <= out_draw;
            end else if (!m_ready) begin
                if (out_wait <= 1) m_ready <= 1'b1;
                out_wait <= out_wait - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_bilinear_table_lookup failed");
            $finish;
        end
    end

    row_t directed [] = '{
        '{blt_pkg::ACT_LOAD_ROW, 0, -32768, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_ROW, 1, 32767, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_COLUMN, 0, 0, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_COLUMN, 1, 65535, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_CELL, 0, -32768, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_CELL, 1, 100, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_CELL, 2, 32767, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_CELL, 3, -1, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOOKUP, 0, 0, -32768, 0, 1, -32768},
        '{blt_pkg::ACT_LOOKUP, 0, 0, 32767, 0, 1, 32767},
        '{blt_pkg::ACT_LOOKUP, 0, 0, -32768, 65535, 1, 100},
        '{blt_pkg::ACT_LOOKUP, 0, 0, 32767, 65535, 1, -1},
        '{blt_pkg::ACT_LOOKUP, 0, 0, 0, 32768, 0, 0},
        '{blt_pkg::ACT_LOAD_ROW, 200, 5, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_COLUMN, 255, 5, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_CELL, 255, 5, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_COLUMN, 1, 0, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOOKUP, 0, 0, 32767, 12345, 1, 32767},
        '{blt_pkg::ACT_LOAD_ROW, 1, -32768, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOOKUP, 0, 0, 5, 7, 1, -32768},
        '{blt_pkg::ACT_LOAD_ROW, 1, 65535, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOAD_COLUMN, 1, 300, 0, 0, 0, 0},
        '{blt_pkg::ACT_LOOKUP, 0, 0, -32768, 150, 0, 0},
        '{blt_pkg::ACT_LOOKUP, 0, 0, -100, 65535, 0, 0}
    };

    initial begin
        int nr, nc;
        rows_cfg = 5'd2;
        cols_cfg = 5'd2;
        foreach (row_bp[i]) row_bp[i] = '0;
        foreach (col_bp[i]) col_bp[i] = '0;
        foreach (cells[i]) cells[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            send_word(directed[i].act, directed[i].idx, directed[i].val,
                      directed[i].qr, directed[i].qc);
            if (directed[i].known)
                pending_values[pending_values.size()-1] = 16'(directed[i].want);
        end
        drain();
        foreach (cfg_r[k]) begin
            write_reg(blt_pkg::REG_ROW_POINTS, cfg_r[k]);
            write_reg(blt_pkg::REG_COLUMN_POINTS, cfg_c[k]);
            for (int pass = 0; pass < 2; pass++) begin
                fill_table(pass[0]);
                nr = npts(rows_cfg, blt_pkg::MAX_ROWS);
                nc = npts(cols_cfg, blt_pkg::MAX_COLUMNS);
                for (int n = 0; n < 14; n++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(blt_pkg::action_t'($urandom_range(0, 2)),
                                  $urandom_range(0, 255),
                                  $urandom_range(0, 98303) - 32768, $urandom, $urandom);
                    else if ($urandom_range(0, 3) == 0)
                        send_word(blt_pkg::ACT_LOOKUP, $urandom_range(0, 255),
                                  $urandom_range(0, 98303) - 32768,
                                  $urandom_range(0, 65535), $urandom_range(0, 65535));
                    else
                        send_word(blt_pkg::ACT_LOOKUP, $urandom_range(0, 255), 0,
                                  int'(row_bp[0]) + $urandom_range(0, 4) - 2
                                  + $urandom_range(0, int'(row_bp[nr-1]) - int'(row_bp[0])
                                  + 2 > 0 ? int'(row_bp[nr-1]) - int'(row_bp[0]) + 2 : 0),
                                  int'(col_bp[0]) + $urandom_range(0, int'(col_bp[nc-1])
                                  - int'(col_bp[0]) + 2));
                end
            end
            drain();
        end
        drain();
        if (mismatches == 0 && pending_values.size() == 0) begin
            $display("tb_bilinear_table_lookup passed");
        end else begin
            $display("tb_bilinear_table_lookup failed");
        end
        $finish;
    end
endmodule
